FILE: sv/sgdm_pkg.sv
// Shared constants and register codes for the SGD momentum update core.
package sgdm_pkg;

    // Coefficient registers are unsigned fixed point of this width
    localparam int COEF_W = 16;

    // Default data and coefficient formats
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Configuration register index
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOMENTUM      = 3'd0,
        REG_LEARNING_RATE = 3'd1,
        REG_WEIGHT_DECAY  = 3'd2,
        REG_NESTEROV_MODE = 3'd3
    } t_cfg_reg;

endpackage

FILE: sv/sgdm_mac.sv
// Registered coefficient multiply with floor shift and clip to the data range.
module sgdm_mac #(
    parameter int DATA_WIDTH     = sgdm_pkg::DATA_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sgdm_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic [sgdm_pkg::COEF_W-1:0]  i_coef,
    output logic signed [DATA_WIDTH-1:0] o_q,
    output logic                         o_clip
);

    localparam int PW = DATA_WIDTH + sgdm_pkg::COEF_W + 1;

    logic signed [PW-1:0]         n_prod;
    logic signed [PW-1:0]         r_prod;
    logic signed [PW-1:0]         w_shift;
    logic [PW-DATA_WIDTH:0]       w_hi;

    // Exact signed product, coefficient taken as unsigned
    assign n_prod = PW'(i_x) * PW'($signed({1'b0, i_coef}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Arithmetic shift rounds toward minus infinity
    assign w_shift = r_prod >>> COEF_FRAC_BITS;
    assign w_hi    = w_shift[PW-1:DATA_WIDTH-1];

    // Clip when the bits above the sign do not all match it
    always_comb begin
        o_clip = !((&w_hi) || (~|w_hi));
        if (o_clip) begin
            o_q = w_shift[PW-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else begin
            o_q = w_shift[DATA_WIDTH-1:0];
        end
    end

endmodule

FILE: sv/sgd_momentum_update_core.sv
// Top level of the SGD momentum update core: config registers and update pipeline.
//
// Streams one parameter element per clock: each transfer carries a parameter, its
// gradient and its stored velocity, and returns the updated parameter and velocity
// (saturated, with a flag) plus the passed-through last marker. The pipeline depth
// comes from the chain of four dependent coefficient multiplies (weight decay,
// learning rate, and in Nesterov mode momentum and learning rate again), each
// with its own product register followed by a shift, clip and saturating add
// stage. With the output taken every cycle the core sustains one element per
// cycle; when the output stalls the whole pipeline holds and input ready drops.
// Write the coefficient registers only while no element is in flight.
module sgd_momentum_update_core #(
    parameter int DATA_WIDTH     = sgdm_pkg::DATA_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sgdm_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgdm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [DATA_WIDTH-1:0]     i_param_in,
    input  logic signed [DATA_WIDTH-1:0]     i_gradient,
    input  logic signed [DATA_WIDTH-1:0]     i_velocity_in,
    input  logic                             i_last_in,
    // output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [DATA_WIDTH-1:0]     o_param_out,
    output logic signed [DATA_WIDTH-1:0]     o_velocity_out,
    output logic                             o_saturated,
    output logic                             o_last_out
);

    localparam int CW     = sgdm_pkg::COEF_W;
    localparam int STAGES = 8;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Saturating add and subtract; the top bit of the result is the clip flag
    function automatic logic [DATA_WIDTH:0] f_sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return {1'b1, (s[DATA_WIDTH] ? DMIN : DMAX)};
        end
        return {1'b0, s[DATA_WIDTH-1:0]};
    endfunction

    function automatic logic [DATA_WIDTH:0] f_sat_sub(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return {1'b1, (s[DATA_WIDTH] ? DMIN : DMAX)};
        end
        return {1'b0, s[DATA_WIDTH-1:0]};
    endfunction

    // Configuration registers
    logic [CW-1:0] r_mom;
    logic [CW-1:0] r_lr;
    logic [CW-1:0] r_wd;
    logic          r_nest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mom  <= '0;
            r_lr   <= '0;
            r_wd   <= '0;
            r_nest <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgdm_pkg::REG_MOMENTUM:      r_mom  <= i_cfg_data[CW-1:0];
                sgdm_pkg::REG_LEARNING_RATE: r_lr   <= i_cfg_data[CW-1:0];
                sgdm_pkg::REG_WEIGHT_DECAY:  r_wd   <= i_cfg_data[CW-1:0];
                sgdm_pkg::REG_NESTEROV_MODE: r_nest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage advances together unless the output stalls
    logic [STAGES-1:0] r_vld;
    logic              w_en;
    logic              w_acc;

    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], w_acc};
        end
    end

    // Multiply units (product register inside each)
    logic signed [DATA_WIDTH-1:0] w_wd_q, w_vm_q, w_lg_q, w_nm_q, w_el_q;
    logic                         w_wd_c, w_vm_c, w_lg_c, w_nm_c, w_el_c;

    // Stage payload registers
    logic signed [DATA_WIDTH-1:0] r_a_p, r_a_g;
    logic                         r_a_last;
    logic signed [DATA_WIDTH-1:0] r_b_p, r_b_g, r_b_vm;
    logic                         r_b_sat, r_b_last;
    logic signed [DATA_WIDTH-1:0] r_c_p, r_c_g, r_c_vm;
    logic                         r_c_sat, r_c_last;
    logic signed [DATA_WIDTH-1:0] r_d_p, r_d_g, r_d_v;
    logic                         r_d_sat, r_d_last;
    logic signed [DATA_WIDTH-1:0] r_e_p, r_e_g, r_e_v, r_e_np;
    logic                         r_e_sat, r_e_std_sat, r_e_last;
    logic signed [DATA_WIDTH-1:0] r_f_p, r_f_eff, r_f_v, r_f_np;
    logic                         r_f_sat, r_f_std_sat, r_f_nst_sat, r_f_last;
    logic signed [DATA_WIDTH-1:0] r_g_p, r_g_v, r_g_np;
    logic                         r_g_sat, r_g_std_sat, r_g_nst_sat, r_g_last;
    logic signed [DATA_WIDTH-1:0] r_h_p, r_h_v;
    logic                         r_h_sat, r_h_last;

    logic [DATA_WIDTH:0] w_g2, w_vnew, w_np_std, w_eff, w_np_nst;
    logic signed [DATA_WIDTH-1:0] n_h_p;
    logic                         n_h_sat;

    // Stage A: weight decay and momentum products
    sgdm_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_wd (
        .i_clk(i_clk), .i_en(w_en), .i_x(i_param_in), .i_coef(r_wd),
        .o_q(w_wd_q), .o_clip(w_wd_c)
    );
    sgdm_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_vm (
        .i_clk(i_clk), .i_en(w_en), .i_x(i_velocity_in), .i_coef(r_mom),
        .o_q(w_vm_q), .o_clip(w_vm_c)
    );

    // Stage C: learning rate times decayed gradient
    sgdm_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_lg (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_b_g), .i_coef(r_lr),
        .o_q(w_lg_q), .o_clip(w_lg_c)
    );

    // Stage E: momentum times new velocity
    sgdm_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_nm (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_d_v), .i_coef(r_mom),
        .o_q(w_nm_q), .o_clip(w_nm_c)
    );

    // Stage G: learning rate times effective gradient
    sgdm_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac_el (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_f_eff), .i_coef(r_lr),
        .o_q(w_el_q), .o_clip(w_el_c)
    );

    // Saturating sums between the product stages
    assign w_g2     = f_sat_add(r_a_g, w_wd_q);
    assign w_vnew   = f_sat_add(r_c_vm, w_lg_q);
    assign w_np_std = f_sat_sub(r_d_p, r_d_v);
    assign w_eff    = f_sat_add(r_e_g, w_nm_q);
    assign w_np_nst = f_sat_sub(r_g_p, w_el_q);

    // Select the parameter update and collect clip flags for the mode
    always_comb begin
        if (r_nest) begin
            n_h_p   = w_np_nst[DATA_WIDTH-1:0];
            n_h_sat = r_g_sat || r_g_nst_sat || w_el_c || w_np_nst[DATA_WIDTH];
        end else begin
            n_h_p   = r_g_np;
            n_h_sat = r_g_sat || r_g_std_sat;
        end
    end

    // Advance payload along the pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_p       <= i_param_in;
            r_a_g       <= i_gradient;
            r_a_last    <= i_last_in;

            r_b_p       <= r_a_p;
            r_b_g       <= w_g2[DATA_WIDTH-1:0];
            r_b_vm      <= w_vm_q;
            r_b_sat     <= w_wd_c || w_vm_c || w_g2[DATA_WIDTH];
            r_b_last    <= r_a_last;

            r_c_p       <= r_b_p;
            r_c_g       <= r_b_g;
            r_c_vm      <= r_b_vm;
            r_c_sat     <= r_b_sat;
            r_c_last    <= r_b_last;

            r_d_p       <= r_c_p;
            r_d_g       <= r_c_g;
            r_d_v       <= w_vnew[DATA_WIDTH-1:0];
            r_d_sat     <= r_c_sat || w_lg_c || w_vnew[DATA_WIDTH];
            r_d_last    <= r_c_last;

            r_e_p       <= r_d_p;
            r_e_g       <= r_d_g;
            r_e_v       <= r_d_v;
            r_e_np      <= w_np_std[DATA_WIDTH-1:0];
            r_e_sat     <= r_d_sat;
            r_e_std_sat <= w_np_std[DATA_WIDTH];
            r_e_last    <= r_d_last;

            r_f_p       <= r_e_p;
            r_f_eff     <= w_eff[DATA_WIDTH-1:0];
            r_f_v       <= r_e_v;
            r_f_np      <= r_e_np;
            r_f_sat     <= r_e_sat;
            r_f_std_sat <= r_e_std_sat;
            r_f_nst_sat <= w_nm_c || w_eff[DATA_WIDTH];
            r_f_last    <= r_e_last;

            r_g_p       <= r_f_p;
            r_g_v       <= r_f_v;
            r_g_np      <= r_f_np;
            r_g_sat     <= r_f_sat;
            r_g_std_sat <= r_f_std_sat;
            r_g_nst_sat <= r_f_nst_sat;
            r_g_last    <= r_f_last;

            r_h_p       <= n_h_p;
            r_h_v       <= r_g_v;
            r_h_sat     <= n_h_sat;
            r_h_last    <= r_g_last;
        end
    end

    assign o_valid        = r_vld[STAGES-1];
    assign o_param_out    = r_h_p;
    assign o_velocity_out = r_h_v;
    assign o_saturated    = r_h_sat;
    assign o_last_out     = r_h_last;

    // Hold input ready low while the output is stalled
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input ready high while output stalled");

    // An element in the last inner stage reaches the output on an advance
    a_reach_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[STAGES-2]) |=> o_valid)
        else $error("element lost before output");

    // Freeze the valid chain while stalled
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");

endmodule

FILE: test/tb_sgd_momentum_update_core.sv
// Self-checking testbench for the SGD momentum update core: predicted vs. observed updates.
module tb_sgd_momentum_update_core;

    localparam int DW             = sgdm_pkg::DATA_WIDTH_DEF;
    localparam int CFW            = sgdm_pkg::COEF_FRAC_BITS_DEF;
    localparam int CW             = sgdm_pkg::COEF_W;
    localparam int IW             = sgdm_pkg::CFG_IDX_W;
    localparam int CDW            = sgdm_pkg::CFG_DATA_W;
    localparam int NUM_REGS       = 4;
    localparam int NUM_PHASES     = 21;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int STALL_LIMIT    = 2000;
    localparam int PIPE_SLACK     = 20;

    localparam longint DMAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint DMIN = -DMAX - 1;
    localparam logic [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] W_ONE = DW'(1) << CFW;

    typedef struct packed {
        logic [DW-1:0] param;
        logic [DW-1:0] grad;
        logic [DW-1:0] vel;
        logic          last;
    } t_elem;

    typedef struct packed {
        logic [DW-1:0] param;
        logic [DW-1:0] vel;
        logic          sat;
        logic          last;
    } t_upd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [IW-1:0]         i_cfg_idx = '0;
    logic [CDW-1:0]        i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [DW-1:0]  i_param_in = '0;
    logic signed [DW-1:0]  i_gradient = '0;
    logic signed [DW-1:0]  i_velocity_in = '0;
    logic                  i_last_in = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [DW-1:0]  o_param_out;
    logic signed [DW-1:0]  o_velocity_out;
    logic                  o_saturated;
    logic                  o_last_out;

    // testbench copy of the coefficient registers
    logic [CW-1:0] mom_reg = '0;
    logic [CW-1:0] lr_reg = '0;
    logic [CW-1:0] wd_reg = '0;
    logic          nest_reg = 1'b0;

    t_elem pending_elems[$];
    t_upd  expected_updates[$];
    t_elem next_elem;
    t_upd  want_upd;
    t_upd  got_upd;
    logic  in_taken = 1'b0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    mismatch_cnt = 0;
    int    stall_cnt = 0;
    bit    clip_seen;

    sgd_momentum_update_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_param_in     (i_param_in),
        .i_gradient     (i_gradient),
        .i_velocity_in  (i_velocity_in),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_param_out    (o_param_out),
        .o_velocity_out (o_velocity_out),
        .o_saturated    (o_saturated),
        .o_last_out     (o_last_out)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Clip to the signed data range and remember any clip
    function automatic longint clip_data(longint x);
        if (x > DMAX) begin
            clip_seen = 1'b1;
            return DMAX;
        end
        if (x < DMIN) begin
            clip_seen = 1'b1;
            return DMIN;
        end
        return x;
    endfunction

    // Exact coefficient product, floored back to the data format
    function automatic longint coef_scale(longint x, logic [CW-1:0] c);
        return (x * longint'(c)) >>> CFW;
    endfunction

    function automatic t_upd predict_update(t_elem e);
        longint p, g, v, eff, np;
        t_upd   r;
        clip_seen = 1'b0;
        p = longint'($signed(e.param));
        g = longint'($signed(e.grad));
        v = longint'($signed(e.vel));
        // fold in weight decay, then form the new velocity
        g = clip_data(g + clip_data(coef_scale(p, wd_reg)));
        v = clip_data(clip_data(coef_scale(v, mom_reg)) + clip_data(coef_scale(g, lr_reg)));
        if (nest_reg) begin
            eff = clip_data(g + clip_data(coef_scale(v, mom_reg)));
            np  = clip_data(p - clip_data(coef_scale(eff, lr_reg)));
        end else begin
            np = clip_data(p - v);
        end
        r.param = np[DW-1:0];
        r.vel   = v[DW-1:0];
        r.sat   = clip_seen;
        r.last  = e.last;
        return r;
    endfunction

    // Mix extremes, small values and wide random words
    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return W_MAX - DW'($urandom_range(0, 3));
            1: return W_MIN + DW'($urandom_range(0, 3));
            2: return DW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            3: return $signed($urandom) >>> $urandom_range(0, DW - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CW'($urandom_range(0, 255));
            default: return CW'($urandom_range(0, (1 << CW) - 1));
        endcase
    endfunction

    task automatic cfg_write(input logic [IW-1:0] idx, input logic [CDW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            sgdm_pkg::REG_MOMENTUM:      mom_reg = val;
            sgdm_pkg::REG_LEARNING_RATE: lr_reg = val;
            sgdm_pkg::REG_WEIGHT_DECAY:  wd_reg = val;
            sgdm_pkg::REG_NESTEROV_MODE: nest_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [CW-1:0] mom, input logic [CW-1:0] lr,
                                input logic [CW-1:0] wd, input logic [CDW-1:0] nest);
        cfg_write(sgdm_pkg::REG_MOMENTUM, mom);
        cfg_write(sgdm_pkg::REG_LEARNING_RATE, lr);
        cfg_write(sgdm_pkg::REG_WEIGHT_DECAY, wd);
        cfg_write(sgdm_pkg::REG_NESTEROV_MODE, nest);
        // unlisted index must leave every register alone
        if ($urandom_range(0, 1))
            cfg_write(IW'($urandom_range(NUM_REGS, (1 << IW) - 1)), CDW'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until nothing is queued, offered or in flight
    task automatic drain_pipeline();
        @(negedge i_clk);
        while (pending_elems.size() != 0 || i_valid || expected_updates.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: offer the next queued element, hold payload until transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_elems.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_elem = pending_elems.pop_front();
                i_valid       <= 1'b1;
                i_param_in    <= next_elem.param;
                i_gradient    <= next_elem.grad;
                i_velocity_in <= next_elem.vel;
                i_last_in     <= next_elem.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: randomly throttle the output channel
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Predict on input transfer, check on output transfer, watch for a hang
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready)
                expected_updates.push_back(predict_update(
                    {i_param_in, i_gradient, i_velocity_in, i_last_in}));
            if (o_valid && i_ready) begin
                got_upd = {o_param_out, o_velocity_out, o_saturated, o_last_out};
                if (expected_updates.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: param %h vel %h sat %b last %b",
                                 got_upd.param, got_upd.vel, got_upd.sat, got_upd.last);
                    mismatch_cnt++;
                end else begin
                    want_upd = expected_updates.pop_front();
                    if (got_upd !== want_upd) begin
                        if (mismatch_cnt < 10)
                            $display("exp/act param %h/%h vel %h/%h sat %b/%b last %b/%b",
                                     want_upd.param, got_upd.param, want_upd.vel, got_upd.vel,
                                     want_upd.sat, got_upd.sat, want_upd.last, got_upd.last);
                        mismatch_cnt++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", stall_cnt);
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    initial begin
        t_elem dir_items[8];
        t_elem e;
        int    mode;
        dir_items[0] = '{W_MAX, W_MAX, W_MAX, 1'b0};
        dir_items[1] = '{W_MIN, W_MIN, W_MIN, 1'b1};
        dir_items[2] = '{'0, '0, '0, 1'b0};
        dir_items[3] = '{'1, '1, '1, 1'b1};
        dir_items[4] = '{W_MAX, W_MIN, W_MAX, 1'b0};
        dir_items[5] = '{W_MIN, W_MAX, W_MIN, 1'b1};
        dir_items[6] = '{DW'(1), '1, W_ONE, 1'b0};
        dir_items[7] = '{W_ONE, W_MAX - W_ONE, -W_ONE, 1'b1};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipeline();
            // first receiver-light, then sender-light, then no idling
            mode = ph * 3 / NUM_PHASES;
            tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 79 : 0;
            rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 34 : 0;
            // phase 0 runs on the reset coefficients; upper bits of the mode write are ignored
            if (ph == 1)
                apply_config('1, '1, '1, CDW'(1));
            else if (ph == 2)
                apply_config('1, '1, '1, CDW'(16'hFFFE));
            else if (ph > 2)
                apply_config(rand_coef(), rand_coef(), rand_coef(), CDW'($urandom));
            if (ph < 3) begin
                foreach (dir_items[k])
                    pending_elems.push_back(dir_items[k]);
            end else begin
                repeat (ITEMS_PER_PHASE) begin
                    e.param = rand_word();
                    e.grad  = rand_word();
                    e.vel   = rand_word();
                    e.last  = ($urandom_range(0, 7) == 0);
                    pending_elems.push_back(e);
                end
            end
        end

        drain_pipeline();
        repeat (PIPE_SLACK) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_updates.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sgd_momentum_update_core.f
sv/sgdm_pkg.sv
sv/sgdm_mac.sv
sv/sgd_momentum_update_core.sv
test/tb_sgd_momentum_update_core.sv
